@@ sv/rstat_pkg.sv @@
`timescale 1ns / 1ps

package rstat_pkg;

    localparam int MAX_ITEMS_DEF = 4096;

    localparam int VAL_W   = 24;   // input value width
    localparam int ERR_W   = 25;   // absolute error width
    localparam int ESUM_W  = 37;   // error sum width
    localparam int SQSUM_W = 62;   // squared error sum width
    localparam int XSUM_W  = 36;   // expected sum width (signed)
    localparam int NORM_W  = 32;
    localparam int CNT_O_W = 13;   // item count port width
    localparam int WRK_W   = 76;   // work register width of the shared unit
    localparam int ADD_W   = WRK_W + 1;
    localparam int REM_W   = 37;
    localparam int DSR_W   = 36;
    localparam int ROOT_W  = 32;
    localparam int STEP_W  = 7;
    localparam int OUT_W   = 184;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_SQR,
        ST_ADDSQ,
        ST_MEAN_LD,
        ST_MEAN_DIV,
        ST_MUL1_LD,
        ST_MUL1,
        ST_MUL2_LD,
        ST_MUL2,
        ST_VAR_LD,
        ST_VAR_DIV,
        ST_SQRT_LD,
        ST_SQRT,
        ST_NORM_LD,
        ST_NORM_DIV,
        ST_EMIT
    } state_t;

endpackage

@@ sv/regression_error_statistics.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Ports                          Contents
// s_       in         s_tvalid s_tready s_tdata      predicted, expected
//                     s_tlast                        last_item
// m_       out        m_tvalid m_tready m_tdata      total, mean, min, max, std,
//                     m_tuser                        normalized mean, count; overflowed
//
// Each input beat is accepted, then its absolute error is formed, then the error
// is squared while the linear sums are updated, and then the square is added.
// A beat that arrives once the set is full is dropped in its accept cycle.
// A beat with tlast then starts the set summary on one shared 77-bit adder:
// three 76-step restoring divisions, two shift-add multiplies (13 and 37 steps)
// and a 32-step square root, after which the result is loaded into the output
// register and the accumulators are cleared.
// Reset (aresetn low, synchronous) clears the accumulators and the output valid.
// The input side is stalled while the summary runs, and while a finished result
// still waits in the output register and a new one is ready to be loaded.
module regression_error_statistics #(
    parameter int MAX_ITEMS = rstat_pkg::MAX_ITEMS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // s_tdata: [23:0] predicted, [47:24] expected
    input  logic [47:0]                s_tdata,
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata: [36:0] total_error, [61:37] mean_error, [86:62] min_error,
    // [111:87] max_error, [136:112] std_error, [168:137] normalized_mean,
    // [181:169] item_count, [183:182] zero
    output logic [rstat_pkg::OUT_W-1:0] m_tdata,
    // m_tuser: [0] overflowed
    output logic [0:0]                 m_tuser
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    rstat_pkg::state_t state_reg, state_next;

    // Captured beat.
    logic signed [rstat_pkg::VAL_W-1:0] pred_reg, expv_reg;
    logic                               last_reg;
    logic [rstat_pkg::ERR_W-1:0]        err_reg;
    logic [2*rstat_pkg::ERR_W-1:0]      sq_reg;

    // Set accumulators.
    logic [CNT_W-1:0]                    count_reg;
    logic [rstat_pkg::ESUM_W-1:0]        esum_reg;
    logic [rstat_pkg::SQSUM_W-1:0]       sqsum_reg;
    logic signed [rstat_pkg::XSUM_W-1:0] xsum_reg;
    logic [rstat_pkg::ERR_W-1:0]         min_reg, max_reg;
    logic                                ovf_reg;

    // Shared unit registers.
    logic [rstat_pkg::WRK_W-1:0]   wa_reg, hold_reg;
    logic [rstat_pkg::REM_W-1:0]   rem_reg;
    logic [rstat_pkg::DSR_W-1:0]   dsr_reg;
    logic [rstat_pkg::SQSUM_W-1:0] mcand_reg;
    logic [rstat_pkg::ESUM_W-1:0]  mplr_reg;
    logic [rstat_pkg::ROOT_W-1:0]  root_reg;
    logic [rstat_pkg::STEP_W-1:0]  step_reg;
    logic [rstat_pkg::ERR_W-1:0]   mean_reg, std_reg;

    logic                          out_valid_reg;
    logic [rstat_pkg::OUT_W-1:0]   out_data_reg;
    logic                          out_ovf_reg;

    // Control decoded from the state, the counters and the handshakes.
    logic in_fire, full, step_last, emit_load, n_small;

    // Shared adder.
    logic [rstat_pkg::WRK_W-1:0] add_a, add_b;
    logic                        add_sub;
    logic [rstat_pkg::ADD_W-1:0] add_sum;
    logic                        add_neg;

    logic [rstat_pkg::REM_W-1:0]   div_rem_sh, sqrt_rem_sh;
    logic [rstat_pkg::CNT_O_W-1:0] count13;
    logic signed [rstat_pkg::ERR_W-1:0] diff;
    logic [2*rstat_pkg::CNT_O_W-1:0] nn1;

    assign count13 = rstat_pkg::CNT_O_W'(count_reg);
    assign full    = (count_reg == CNT_W'(MAX_ITEMS));
    assign n_small = (count13 < rstat_pkg::CNT_O_W'(2));
    assign nn1     = count13 * (count13 - rstat_pkg::CNT_O_W'(1));
    assign diff    = rstat_pkg::ERR_W'(pred_reg) - rstat_pkg::ERR_W'(expv_reg);

    assign div_rem_sh  = {rem_reg[rstat_pkg::REM_W-2:0], wa_reg[rstat_pkg::WRK_W-1]};
    assign sqrt_rem_sh = {rem_reg[rstat_pkg::REM_W-3:0], wa_reg[63:62]};

    // Operand selection for the shared adder.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            rstat_pkg::ST_MEAN_DIV, rstat_pkg::ST_VAR_DIV, rstat_pkg::ST_NORM_DIV: begin
                add_a   = rstat_pkg::WRK_W'(div_rem_sh);
                add_b   = rstat_pkg::WRK_W'(dsr_reg);
                add_sub = 1'b1;
            end
            rstat_pkg::ST_SQRT: begin
                add_a   = rstat_pkg::WRK_W'(sqrt_rem_sh);
                add_b   = rstat_pkg::WRK_W'({root_reg, 2'b01});
                add_sub = 1'b1;
            end
            rstat_pkg::ST_MUL1, rstat_pkg::ST_MUL2: begin
                add_a = {wa_reg[rstat_pkg::WRK_W-2:0], 1'b0};
                add_b = mplr_reg[rstat_pkg::ESUM_W-1] ? rstat_pkg::WRK_W'(mcand_reg) : '0;
            end
            rstat_pkg::ST_VAR_LD: begin
                add_a   = hold_reg;
                add_b   = wa_reg;
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign add_sum = {1'b0, add_a}
                   + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
                   + rstat_pkg::ADD_W'(add_sub);
    assign add_neg = add_sum[rstat_pkg::ADD_W-1];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rstat_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (full) begin
                        state_next = s_tlast ? rstat_pkg::ST_MEAN_LD : rstat_pkg::ST_IDLE;
                    end else begin
                        state_next = rstat_pkg::ST_ERR;
                    end
                end
            end
            rstat_pkg::ST_ERR:   state_next = rstat_pkg::ST_SQR;
            rstat_pkg::ST_SQR:   state_next = rstat_pkg::ST_ADDSQ;
            rstat_pkg::ST_ADDSQ: begin
                state_next = last_reg ? rstat_pkg::ST_MEAN_LD : rstat_pkg::ST_IDLE;
            end
            rstat_pkg::ST_MEAN_LD: state_next = rstat_pkg::ST_MEAN_DIV;
            rstat_pkg::ST_MEAN_DIV: begin
                if (step_last) state_next = rstat_pkg::ST_MUL1_LD;
            end
            rstat_pkg::ST_MUL1_LD: begin
                state_next = n_small ? rstat_pkg::ST_NORM_LD : rstat_pkg::ST_MUL1;
            end
            rstat_pkg::ST_MUL1: begin
                if (step_last) state_next = rstat_pkg::ST_MUL2_LD;
            end
            rstat_pkg::ST_MUL2_LD: state_next = rstat_pkg::ST_MUL2;
            rstat_pkg::ST_MUL2: begin
                if (step_last) state_next = rstat_pkg::ST_VAR_LD;
            end
            rstat_pkg::ST_VAR_LD: state_next = rstat_pkg::ST_VAR_DIV;
            rstat_pkg::ST_VAR_DIV: begin
                if (step_last) state_next = rstat_pkg::ST_SQRT_LD;
            end
            rstat_pkg::ST_SQRT_LD: state_next = rstat_pkg::ST_SQRT;
            rstat_pkg::ST_SQRT: begin
                if (step_last) state_next = rstat_pkg::ST_NORM_LD;
            end
            rstat_pkg::ST_NORM_LD: begin
                state_next = (xsum_reg > 0) ? rstat_pkg::ST_NORM_DIV : rstat_pkg::ST_EMIT;
            end
            rstat_pkg::ST_NORM_DIV: begin
                if (step_last) state_next = rstat_pkg::ST_EMIT;
            end
            rstat_pkg::ST_EMIT: begin
                if (emit_load) state_next = rstat_pkg::ST_IDLE;
            end
            default: state_next = rstat_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_tready  = (state_reg == rstat_pkg::ST_IDLE);
        in_fire   = s_tready && s_tvalid;
        step_last = (step_reg == '0);
        emit_load = (state_reg == rstat_pkg::ST_EMIT) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rstat_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Accumulators and captured beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            esum_reg  <= '0;
            sqsum_reg <= '0;
            xsum_reg  <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            if (in_fire) begin
                pred_reg <= s_tdata[23:0];
                expv_reg <= s_tdata[47:24];
                last_reg <= s_tlast;
                if (full) ovf_reg <= 1'b1;
            end
            case (state_reg)
                rstat_pkg::ST_ERR: begin
                    err_reg <= diff[rstat_pkg::ERR_W-1] ? -diff : diff;
                end
                rstat_pkg::ST_SQR: begin
                    sq_reg    <= err_reg * err_reg;
                    count_reg <= count_reg + CNT_W'(1);
                    esum_reg  <= esum_reg + rstat_pkg::ESUM_W'(err_reg);
                    xsum_reg  <= xsum_reg + rstat_pkg::XSUM_W'(expv_reg);
                    if (err_reg < min_reg) min_reg <= err_reg;
                    if (err_reg > max_reg) max_reg <= err_reg;
                end
                rstat_pkg::ST_ADDSQ: begin
                    sqsum_reg <= sqsum_reg + rstat_pkg::SQSUM_W'(sq_reg);
                end
                default: begin
                end
            endcase
            // The set is done once its result is loaded for the output.
            if (emit_load) begin
                count_reg <= '0;
                esum_reg  <= '0;
                sqsum_reg <= '0;
                xsum_reg  <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // Shared unit sequencing. Each load state after the first also picks up the
    // result of the operation that just finished.
    always_ff @(posedge aclk) begin
        if (state_reg inside {rstat_pkg::ST_MEAN_DIV, rstat_pkg::ST_MUL1, rstat_pkg::ST_MUL2,
                              rstat_pkg::ST_VAR_DIV, rstat_pkg::ST_SQRT,
                              rstat_pkg::ST_NORM_DIV}
            && step_reg != '0) begin
            step_reg <= step_reg - rstat_pkg::STEP_W'(1);
        end
        case (state_reg)
            rstat_pkg::ST_MEAN_LD: begin
                wa_reg   <= rstat_pkg::WRK_W'(esum_reg);
                rem_reg  <= '0;
                dsr_reg  <= rstat_pkg::DSR_W'(count13);
                step_reg <= rstat_pkg::STEP_W'(rstat_pkg::WRK_W - 1);
            end
            rstat_pkg::ST_MEAN_DIV, rstat_pkg::ST_VAR_DIV, rstat_pkg::ST_NORM_DIV: begin
                rem_reg <= add_neg ? div_rem_sh : add_sum[rstat_pkg::REM_W-1:0];
                wa_reg  <= {wa_reg[rstat_pkg::WRK_W-2:0], ~add_neg};
            end
            rstat_pkg::ST_MUL1_LD: begin
                // A count of zero cannot occur but would read as a zero mean.
                mean_reg  <= (count13 == '0) ? '0 : wa_reg[rstat_pkg::ERR_W-1:0];
                wa_reg    <= '0;
                root_reg  <= '0;
                mcand_reg <= sqsum_reg;
                mplr_reg  <= {count13, (rstat_pkg::ESUM_W - rstat_pkg::CNT_O_W)'(0)};
                step_reg  <= rstat_pkg::STEP_W'(rstat_pkg::CNT_O_W - 1);
            end
            rstat_pkg::ST_MUL1, rstat_pkg::ST_MUL2: begin
                wa_reg   <= add_sum[rstat_pkg::WRK_W-1:0];
                mplr_reg <= {mplr_reg[rstat_pkg::ESUM_W-2:0], 1'b0};
            end
            rstat_pkg::ST_MUL2_LD: begin
                hold_reg  <= wa_reg;
                wa_reg    <= '0;
                mcand_reg <= rstat_pkg::SQSUM_W'(esum_reg);
                mplr_reg  <= esum_reg;
                step_reg  <= rstat_pkg::STEP_W'(rstat_pkg::ESUM_W - 1);
            end
            rstat_pkg::ST_VAR_LD: begin
                // n times the square sum never falls below the squared sum.
                wa_reg   <= add_sum[rstat_pkg::WRK_W-1:0];
                rem_reg  <= '0;
                dsr_reg  <= rstat_pkg::DSR_W'(nn1);
                step_reg <= rstat_pkg::STEP_W'(rstat_pkg::WRK_W - 1);
            end
            rstat_pkg::ST_SQRT_LD: begin
                // The variance saturates at 64 bits before the root.
                wa_reg   <= (wa_reg[rstat_pkg::WRK_W-1:64] != '0)
                            ? rstat_pkg::WRK_W'({64{1'b1}})
                            : rstat_pkg::WRK_W'(wa_reg[63:0]);
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= rstat_pkg::STEP_W'(rstat_pkg::ROOT_W - 1);
            end
            rstat_pkg::ST_SQRT: begin
                rem_reg  <= add_neg ? sqrt_rem_sh : add_sum[rstat_pkg::REM_W-1:0];
                root_reg <= {root_reg[rstat_pkg::ROOT_W-2:0], ~add_neg};
                wa_reg   <= {wa_reg[rstat_pkg::WRK_W-3:0], 2'b00};
            end
            rstat_pkg::ST_NORM_LD: begin
                std_reg  <= root_reg[rstat_pkg::ERR_W-1:0];
                wa_reg   <= (xsum_reg > 0)
                            ? rstat_pkg::WRK_W'({esum_reg, 16'h0000}) : '0;
                rem_reg  <= '0;
                dsr_reg  <= xsum_reg;
                step_reg <= rstat_pkg::STEP_W'(rstat_pkg::WRK_W - 1);
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (emit_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
        if (emit_load) begin
            out_data_reg <= {2'b00,
                             count13,
                             (wa_reg[rstat_pkg::WRK_W-1:rstat_pkg::NORM_W] != '0)
                                 ? {rstat_pkg::NORM_W{1'b1}}
                                 : wa_reg[rstat_pkg::NORM_W-1:0],
                             std_reg, max_reg, min_reg, mean_reg, esum_reg};
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule
